/* src/vgrt_pkg.sv */
// ----------------------------------------------------------------------------
// vgrt_pkg
// Shared types and constants of the voxel grid ray traversal block.
// ----------------------------------------------------------------------------
package vgrt_pkg;

  // grid and walk limits
  localparam int GRID_MAX   = 32;
  localparam int STEP_LIMIT = 256;
  localparam int IDX_W      = $clog2(GRID_MAX);
  localparam int SIZE_W     = $clog2(GRID_MAX + 1);
  localparam int ADDR_W     = 3 * IDX_W;
  localparam int GRID_CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int CNT_W      = $clog2(STEP_LIMIT + 1);

  // field widths
  localparam int CFG_SIZE_W = 6;
  localparam int POS_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = 26;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_UNITS  = 2'd3;

  // normal axis codes
  localparam logic [1:0] NRM_NONE = 2'd0;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_WALK   = 7'b0001000,
    ST_DMUL   = 7'b0010000,
    ST_DADD   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0] size_x;
    logic [CFG_SIZE_W-1:0] size_y;
    logic [CFG_SIZE_W-1:0] size_z;
    logic [31:0]           units_per_voxel;
  } cfg_t;

  typedef struct packed {
    logic [14:0]             voxel_address;
    logic [7:0]              voxel_value;
    logic                    entry_missed;
    logic [31:0]             entry_depth;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [2:0]              step_signs;
    logic signed [31:0]      inv_dir_x;
    logic signed [31:0]      inv_dir_y;
    logic signed [31:0]      inv_dir_z;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] depth;
    logic [1:0]  normal_axis;
    logic        normal_negative;
    logic [7:0]  hit_value;
    logic [8:0]  step_count;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic wr;
    logic setup;
    logic walk;
    logic dmul;
    logic dadd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic setup_done;
    logic walk_hit;
    logic walk_miss;
    logic out_free;
  } status_t;

endpackage

/* src/vgrt_ctrl.sv */
// ----------------------------------------------------------------------------
// vgrt_ctrl
// Sequencer: memory clear, voxel writes, ray setup, walk and depth steps.
// ----------------------------------------------------------------------------
module vgrt_ctrl import vgrt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  input  logic    in_missed_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (fire && in_op_i == OP_TRACE) state_d = in_missed_i ? ST_FINISH : ST_SETUP;
      end
      ST_SETUP:  if (status_i.setup_done) state_d = ST_WALK;
      ST_WALK: begin
        if (status_i.walk_hit) state_d = ST_DMUL;
        else if (status_i.walk_miss) state_d = ST_FINISH;
      end
      ST_DMUL:   state_d = ST_DADD;
      ST_DADD:   state_d = ST_FINISH;
      ST_FINISH: if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.load   = fire && (in_op_i == OP_TRACE);
    cmd_o.wr     = fire && (in_op_i == OP_WRITE);
    cmd_o.setup  = (state_q == ST_SETUP);
    cmd_o.walk   = (state_q == ST_WALK);
    cmd_o.dmul   = (state_q == ST_DMUL);
    cmd_o.dadd   = (state_q == ST_DADD);
    cmd_o.finish = (state_q == ST_FINISH) && status_i.out_free;
  end

endmodule

/* src/vgrt_dpath.sv */
// ----------------------------------------------------------------------------
// vgrt_dpath
// Voxel memory, ray registers, shared multiplier, DDA step logic and the
// result register.
// ----------------------------------------------------------------------------
module vgrt_dpath import vgrt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output status_t status_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32'h7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] SAT_MIN = {{(PROD_W-31){1'b1}}, 31'b0};
  localparam logic signed [PROD_W-1:0] DEP_MAX = PROD_W'(33'h0_FFFF_FFFF);

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // voxel memory
  logic [7:0]        mem [GRID_CELLS];
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr, clr_q;
  logic [7:0]        wr_data;
  logic              wr_en;

  // ray state
  logic [IDX_W-1:0]         idx_q [3];
  logic [IDX_W-1:0]         idx_d [3];
  logic signed [POS_W-1:0]  pos_q [3];
  logic signed [31:0]       inv_q [3];
  logic signed [31:0]       tmax_q [3];
  logic [31:0]              delta [3];
  logic signed [DIFF_W-1:0] diff [3];
  logic [SIZE_W-1:0]        size_eff [3];
  logic [CFG_SIZE_W-1:0]    size_cfg [3];
  logic [2:0]               signs_q;
  logic [31:0]              entry_q;
  logic signed [31:0]       t_q;
  logic [1:0]               axis_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [1:0]               ax_q;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_sh, dep_sum;

  // walk decisions
  logic       at_limit, is_hit, leaving, do_step;
  logic [1:0] k_sel;
  logic       leave_k [3];

  // result
  result_t res_q;
  logic    out_valid_q;

  assign size_cfg[0] = cfg_i.size_x;
  assign size_cfg[1] = cfg_i.size_y;
  assign size_cfg[2] = cfg_i.size_z;

  // per-axis effective size, start offset and step increment
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (size_cfg[k] == '0) size_eff[k] = SIZE_W'(1);
      else if (SIZE_W'(size_cfg[k]) > SIZE_W'(GRID_MAX)) size_eff[k] = SIZE_W'(GRID_MAX);
      else size_eff[k] = SIZE_W'(size_cfg[k]);
      diff[k] = $signed(DIFF_W'({idx_q[k], {FRAC_W{1'b0}}})) - DIFF_W'(pos_q[k])
              + (signs_q[k] ? DIFF_W'(0) : DIFF_W'(1 << FRAC_W));
      if (inv_q[k] == 32'sh8000_0000) delta[k] = 32'h7FFF_FFFF;
      else if (inv_q[k] < 0) delta[k] = 32'(-inv_q[k]);
      else delta[k] = 32'(inv_q[k]);
      leave_k[k] = signs_q[k] ? (idx_q[k] == '0)
                              : (SIZE_W'({1'b0, idx_q[k]}) + SIZE_W'(1) >= size_eff[k]);
    end
  end

  // multiplier operands: tmax setup per axis, then t times units per voxel
  always_comb begin
    if (cmd_i.dmul) begin
      mul_a = MUL_W'(t_q);
      mul_b = $signed({1'b0, cfg_i.units_per_voxel});
    end else begin
      mul_a = MUL_W'(diff[(ax_q == 2'd3) ? 2'd2 : ax_q]);
      mul_b = MUL_W'(inv_q[(ax_q == 2'd3) ? 2'd2 : ax_q]);
    end
  end

  assign prod_sh = prod_q >>> FRAC_W;
  assign dep_sum = prod_sh + $signed(PROD_W'(entry_q));

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // axis choice, ties go to z then y
  always_comb begin
    if (tmax_q[0] < tmax_q[1]) k_sel = (tmax_q[0] < tmax_q[2]) ? 2'd0 : 2'd2;
    else k_sel = (tmax_q[1] < tmax_q[2]) ? 2'd1 : 2'd2;
  end

  assign at_limit = (cnt_q == CNT_W'(STEP_LIMIT));
  assign is_hit   = !at_limit && (rd_q != 8'h00);
  assign leaving  = leave_k[k_sel];
  assign do_step  = cmd_i.walk && !at_limit && !is_hit && !leaving;

  // next voxel index: clamped start on load, one step during the walk
  always_comb begin
    logic signed [8:0] fl;
    logic signed [8:0] hi;
    logic signed [POS_W-1:0] p;
    for (int k = 0; k < 3; k++) begin
      idx_d[k] = idx_q[k];
      p  = (k == 0) ? item_i.pos_x : (k == 1) ? item_i.pos_y : item_i.pos_z;
      fl = 9'(p >>> FRAC_W);
      hi = $signed(9'(size_eff[k]) - 9'd1);
      if (cmd_i.load) begin
        if (fl < 0) idx_d[k] = '0;
        else if (fl > hi) idx_d[k] = IDX_W'(hi);
        else idx_d[k] = IDX_W'(fl);
      end else if (do_step && k_sel == 2'(k)) begin
        idx_d[k] = signs_q[k] ? idx_q[k] - IDX_W'(1) : idx_q[k] + IDX_W'(1);
      end
    end
  end

  assign rd_addr = {idx_d[2], idx_d[1], idx_d[0]};
  assign wr_en   = cmd_i.clear
                || (cmd_i.wr && (32'(item_i.voxel_address) < 32'(GRID_CELLS)));
  assign wr_addr = cmd_i.clear ? clr_q : item_i.voxel_address[ADDR_W-1:0];
  assign wr_data = cmd_i.clear ? 8'h00 : item_i.voxel_value;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // ray registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) idx_q[k] <= idx_d[k];
    if (cmd_i.load) begin
      pos_q[0] <= item_i.pos_x;
      pos_q[1] <= item_i.pos_y;
      pos_q[2] <= item_i.pos_z;
      inv_q[0] <= item_i.inv_dir_x;
      inv_q[1] <= item_i.inv_dir_y;
      inv_q[2] <= item_i.inv_dir_z;
      signs_q  <= item_i.step_signs;
      entry_q  <= item_i.entry_depth;
      t_q      <= '0;
      axis_q   <= NRM_NONE;
    end
    if (cmd_i.setup && ax_q != 2'd0) tmax_q[ax_q - 2'd1] <= sat32(prod_sh);
    if (do_step) begin
      logic signed [32:0] sum;
      sum = {tmax_q[k_sel][31], tmax_q[k_sel]} + $signed({1'b0, delta[k_sel]});
      t_q    <= tmax_q[k_sel];
      axis_q <= k_sel + 2'd1;
      tmax_q[k_sel] <= (sum[32] != sum[31]) ? 32'sh7FFF_FFFF : sum[31:0];
    end
  end

  // setup axis counter and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load) ax_q <= '0;
      else if (cmd_i.setup) ax_q <= ax_q + 2'd1;
      if (cmd_i.load) cnt_q <= '0;
      else if (do_step) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // result assembly
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= '{hit: 1'b0, depth: 32'hFFFF_FFFF, normal_axis: NRM_NONE,
                 normal_negative: 1'b0, hit_value: 8'h00, step_count: 9'd0};
    end
    if (cmd_i.walk && is_hit) begin
      res_q.hit             <= 1'b1;
      res_q.hit_value       <= rd_q;
      res_q.step_count      <= 9'(cnt_q);
      res_q.normal_axis     <= axis_q;
      res_q.normal_negative <= (axis_q != NRM_NONE) && !signs_q[axis_q - 2'd1];
    end else if (cmd_i.walk && (at_limit || leaving)) begin
      res_q.step_count <= 9'(cnt_q);
    end
    if (cmd_i.dadd) begin
      if (dep_sum < 0) res_q.depth <= '0;
      else if (dep_sum > DEP_MAX) res_q.depth <= 32'hFFFF_FFFF;
      else res_q.depth <= dep_sum[31:0];
    end
    if (cmd_i.finish) out_o <= res_q;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.clear_done = cmd_i.clear && (&clr_q);
  assign status_o.setup_done = cmd_i.setup && (ax_q == 2'd3);
  assign status_o.walk_hit   = is_hit;
  assign status_o.walk_miss  = at_limit || leaving;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // the step counter never passes the limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STEP_LIMIT)) else $error("step counter past limit");

  // a step keeps the index inside the grid in use
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(do_step) |-> (SIZE_W'(idx_q[0]) < size_eff[0]) && (SIZE_W'(idx_q[1]) < size_eff[1])
                       && (SIZE_W'(idx_q[2]) < size_eff[2]))
    else $error("voxel index left grid");

  // memory writes never overlap a walk
  a_no_wr_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !cmd_i.walk && !cmd_i.setup) else $error("write during walk");

endmodule

/* src/voxel_grid_ray_traversal.sv */
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal
// 3D DDA ray walk over a byte voxel grid, Q8.16 positions and Q16.16 inverse directions.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 32768-byte voxel memory to zero, one
// entry a cycle, and takes no item until the sweep is done; configuration
// writes are taken at any time. A voxel write is made as it is taken. A trace
// item goes through setup (one shared multiplier, one axis per cycle), then
// the walk at one cycle per voxel visited, since the voxel read for the next
// cell is issued while the current cell is checked, then on a hit the depth
// multiply and add states, and last the finish state to load the output
// register. A missed entry goes from idle straight to the finish state. The
// result sits in an output register, so the next item is taken while it
// waits to be transferred; a new result holds in its finish state while the
// output register still holds one that has not been transferred.
module voxel_grid_ray_traversal import vgrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // voxel_address, voxel_value, entry_missed, entry_depth, pos_x, pos_y,
  // pos_z, step_signs, inv_dir_x, inv_dir_y, inv_dir_z, zero fill
  input  logic [231:0] s_axis_tdata,
  // operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // depth, normal_axis, normal_negative, hit_value, step_count, zero fill
  output logic [55:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  cmd_t    cmd;
  status_t status;
  result_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{size_x: 6'd32, size_y: 6'd32, size_z: 6'd32,
                 units_per_voxel: 32'd65536};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_X: cfg_q.size_x <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_SIZE_Y: cfg_q.size_y <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_SIZE_Z: cfg_q.size_z <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_UNITS:  cfg_q.units_per_voxel <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input field unpacking
  assign item.voxel_address = s_axis_tdata[14:0];
  assign item.voxel_value   = s_axis_tdata[22:15];
  assign item.entry_missed  = s_axis_tdata[23];
  assign item.entry_depth   = s_axis_tdata[55:24];
  assign item.pos_x         = s_axis_tdata[79:56];
  assign item.pos_y         = s_axis_tdata[103:80];
  assign item.pos_z         = s_axis_tdata[127:104];
  assign item.step_signs    = s_axis_tdata[130:128];
  assign item.inv_dir_x     = s_axis_tdata[162:131];
  assign item.inv_dir_y     = s_axis_tdata[194:163];
  assign item.inv_dir_z     = s_axis_tdata[226:195];

  vgrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_missed_i (item.entry_missed),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vgrt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // result packing
  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {4'b0, res.step_count, res.hit_value, res.normal_negative,
                         res.normal_axis, res.depth};

endmodule
